### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define WBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define WBP_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wbp_pkg.sv
// Types, constants and CAT02 coefficient tables of the XYZ white balance block
`default_nettype none
package wbp_pkg;

	localparam int PIX_W          = 16;
	localparam int REG_W          = 16;
	localparam int OUT_W          = 18;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int COEF_FRAC      = 16;
	localparam int LMS_EXTRA      = 8;
	localparam int COEF_W         = 18;
	localparam int NUM_STAGES     = 7;
	localparam int CFG_IDX_W      = 3;
	// width of the per-channel result handed to the clip stage
	localparam int SEL_W          = 28;
	localparam int LMS_RES_W      = 26;
	localparam int CHR_X_W        = 25;
	localparam int CHR_Z_W        = 28;

	typedef logic signed [COEF_W-1:0] coef_t;

	// Q.16 CAT02 forward and inverse matrices
	localparam coef_t CAT_FWD [0:2][0:2] = '{
		'{ 18'sd48025,  18'sd28154, -18'sd10643},
		'{-18'sd46111,  18'sd111247, 18'sd400  },
		'{ 18'sd197,    18'sd891,    18'sd64448}
	};

	localparam coef_t CAT_INV [0:2][0:2] = '{
		'{ 18'sd71834, -18'sd18278,  18'sd11973},
		'{ 18'sd29780,  18'sd31031,  18'sd4725 },
		'{-18'sd629,   -18'sd374,    18'sd66539}
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USE_LMS   = 3'd0,
		REG_RATIO_X   = 3'd1,
		REG_RATIO_Y   = 3'd2,
		REG_RECIP_RY  = 3'd3,
		REG_GAIN_L    = 3'd4,
		REG_GAIN_M    = 3'd5,
		REG_GAIN_S    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic             use_lms;
		logic [REG_W-1:0] ratio_x;
		logic [REG_W-1:0] ratio_y;
		logic [REG_W-1:0] recip_ratio_y;
		logic [REG_W-1:0] gain_l;
		logic [REG_W-1:0] gain_m;
		logic [REG_W-1:0] gain_s;
	} cfg_t;

	// load enable of each pipeline stage, bit 0 is stage one
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctl_t;

endpackage
`default_nettype wire

### rtl/wbp_cfg_regs.sv
// Configuration register file of the white balance block
`default_nettype none
module wbp_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wbp_pkg::REG_W-1:0]      cfg_data,
	output wbp_pkg::cfg_t                       cfg
);

	localparam logic [wbp_pkg::REG_W-1:0] UNITY = wbp_pkg::REG_W'(2**wbp_pkg::GAIN_FRAC_BITS);

	wbp_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_lms       <= 1'b0;
			cfg_q.ratio_x       <= UNITY;
			cfg_q.ratio_y       <= UNITY;
			cfg_q.recip_ratio_y <= UNITY;
			cfg_q.gain_l        <= UNITY;
			cfg_q.gain_m        <= UNITY;
			cfg_q.gain_s        <= UNITY;
		end else if (cfg_valid) begin
			unique case (wbp_pkg::cfg_reg_t'(cfg_index))
				wbp_pkg::REG_USE_LMS:  cfg_q.use_lms       <= cfg_data[0];
				wbp_pkg::REG_RATIO_X:  cfg_q.ratio_x       <= cfg_data;
				wbp_pkg::REG_RATIO_Y:  cfg_q.ratio_y       <= cfg_data;
				wbp_pkg::REG_RECIP_RY: cfg_q.recip_ratio_y <= cfg_data;
				wbp_pkg::REG_GAIN_L:   cfg_q.gain_l        <= cfg_data;
				wbp_pkg::REG_GAIN_M:   cfg_q.gain_m        <= cfg_data;
				wbp_pkg::REG_GAIN_S:   cfg_q.gain_s        <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/wbp_pipe_ctrl.sv
// Valid bits and per-stage load enables of the pixel pipeline
`default_nettype none
module wbp_pipe_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output wbp_pkg::pipe_ctl_t ctl
);

	localparam int N = wbp_pkg::NUM_STAGES;

	logic [N-1:0] valid_q;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		ctl.en[N-1] = !valid_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			ctl.en[k] = !valid_q[k] || ctl.en[k+1];
		end
	end

	assign in_ready  = ctl.en[0];
	assign out_valid = valid_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (ctl.en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/wbp_lms_path.sv
// LMS datapath: forward CAT02, cone gains, inverse CAT02, stages one to six
`default_nettype none
module wbp_lms_path (
	input  wire logic                                 clk,
	input  wire wbp_pkg::pipe_ctl_t                   ctl,
	input  wire wbp_pkg::cfg_t                        cfg,
	input  wire logic [wbp_pkg::PIX_W-1:0]            x_in,
	input  wire logic [wbp_pkg::PIX_W-1:0]            y_in,
	input  wire logic [wbp_pkg::PIX_W-1:0]            z_in,
	output logic signed [wbp_pkg::LMS_RES_W-1:0]      res_x,
	output logic signed [wbp_pkg::LMS_RES_W-1:0]      res_y,
	output logic signed [wbp_pkg::LMS_RES_W-1:0]      res_z
);

	localparam int PROD1_W = 34;
	localparam int ACC1_W  = 35;
	localparam int LMS_W   = 26;
	localparam int LG_W    = 42;
	localparam int LMSG_W  = 30;
	localparam int PROD2_W = 48;
	localparam int ACC2_W  = 50;
	localparam int RES_W   = wbp_pkg::LMS_RES_W;
	localparam int SH1     = wbp_pkg::COEF_FRAC - wbp_pkg::LMS_EXTRA;
	localparam int SH2     = wbp_pkg::GAIN_FRAC_BITS;
	localparam int SH3     = wbp_pkg::COEF_FRAC + wbp_pkg::LMS_EXTRA;
	localparam logic signed [ACC1_W-1:0] HALF1 = ACC1_W'(2**(SH1-1));
	localparam logic signed [LG_W-1:0]   HALF2 = LG_W'(2**(SH2-1));
	localparam logic signed [ACC2_W-1:0] HALF3 = ACC2_W'(2**(SH3-1));

	logic [wbp_pkg::PIX_W-1:0]  pix  [3];
	logic [wbp_pkg::REG_W-1:0]  gain [3];

	logic signed [PROD1_W-1:0] fwd_s1  [3][3];
	logic signed [ACC1_W-1:0]  acc1    [3];
	logic signed [LMS_W-1:0]   lms_s2  [3];
	logic signed [LG_W-1:0]    lg_s3   [3];
	logic signed [LMSG_W-1:0]  lmsg_s4 [3];
	logic signed [PROD2_W-1:0] inv_s5  [3][3];
	logic signed [ACC2_W-1:0]  acc2    [3];
	logic signed [RES_W-1:0]   res_s6  [3];

	assign pix[0]  = x_in;
	assign pix[1]  = y_in;
	assign pix[2]  = z_in;
	assign gain[0] = cfg.gain_l;
	assign gain[1] = cfg.gain_m;
	assign gain[2] = cfg.gain_s;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc1[i] = ACC1_W'(fwd_s1[i][0]) + ACC1_W'(fwd_s1[i][1]) + ACC1_W'(fwd_s1[i][2]);
			acc2[i] = ACC2_W'(inv_s5[i][0]) + ACC2_W'(inv_s5[i][1]) + ACC2_W'(inv_s5[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (ctl.en[0]) begin
				for (int j = 0; j < 3; j++) begin
					fwd_s1[i][j] <= PROD1_W'(wbp_pkg::CAT_FWD[i][j])
						* PROD1_W'($signed({1'b0, pix[j]}));
				end
			end
			if (ctl.en[1]) begin
				lms_s2[i] <= LMS_W'((acc1[i] + HALF1) >>> SH1);
			end
			if (ctl.en[2]) begin
				lg_s3[i] <= LG_W'(lms_s2[i]) * LG_W'($signed({1'b0, gain[i]}));
			end
			if (ctl.en[3]) begin
				lmsg_s4[i] <= LMSG_W'((lg_s3[i] + HALF2) >>> SH2);
			end
			if (ctl.en[4]) begin
				for (int j = 0; j < 3; j++) begin
					inv_s5[i][j] <= PROD2_W'(wbp_pkg::CAT_INV[i][j]) * PROD2_W'(lmsg_s4[j]);
				end
			end
			if (ctl.en[5]) begin
				res_s6[i] <= RES_W'((acc2[i] + HALF3) >>> SH3);
			end
		end
	end

	assign res_x = res_s6[0];
	assign res_y = res_s6[1];
	assign res_z = res_s6[2];

endmodule
`default_nettype wire

### rtl/wbp_chroma_path.sv
// Chromaticity ratio datapath, stages one to six
`default_nettype none
module wbp_chroma_path (
	input  wire logic                               clk,
	input  wire wbp_pkg::pipe_ctl_t                 ctl,
	input  wire wbp_pkg::cfg_t                      cfg,
	input  wire logic [wbp_pkg::PIX_W-1:0]          x_in,
	input  wire logic [wbp_pkg::PIX_W-1:0]          y_in,
	input  wire logic [wbp_pkg::PIX_W-1:0]          z_in,
	output logic [wbp_pkg::CHR_X_W-1:0]             res_x,
	output logic [wbp_pkg::PIX_W-1:0]               res_y,
	output logic signed [wbp_pkg::CHR_Z_W-1:0]      res_z
);

	localparam int PR_W  = 2 * wbp_pkg::PIX_W;
	localparam int SUM_W = wbp_pkg::PIX_W + 2;
	localparam int NUM_W = 35;
	localparam int XP_W  = 48;
	localparam int ZP_W  = 52;
	localparam int XR_W  = wbp_pkg::CHR_X_W;
	localparam int ZR_W  = wbp_pkg::CHR_Z_W;
	localparam int SH    = 2 * wbp_pkg::GAIN_FRAC_BITS;
	localparam logic [XP_W:0]          X_HALF = (XP_W + 1)'(2**(SH-1));
	localparam logic signed [ZP_W-1:0] Z_HALF = ZP_W'(2**(SH-1));

	logic [PR_W-1:0]           pxr_s1;
	logic [PR_W-1:0]           pyr_s1;
	logic [SUM_W-1:0]          sum_s1;
	logic [wbp_pkg::PIX_W-1:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6;
	logic signed [NUM_W-1:0]   num;
	logic signed [NUM_W-1:0]   num_s2;
	logic [XP_W-1:0]           xp_s2;
	logic signed [ZP_W-1:0]    zp_s3;
	logic [XR_W-1:0]           xr_s3, xr_s4, xr_s5, xr_s6;
	logic signed [ZR_W-1:0]    zr_s4, zr_s5, zr_s6;

	// sum * 2^G - rx*X - ry*Y
	assign num = $signed(NUM_W'(sum_s1) << wbp_pkg::GAIN_FRAC_BITS)
		- $signed(NUM_W'(pxr_s1)) - $signed(NUM_W'(pyr_s1));

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			pxr_s1 <= PR_W'(x_in) * PR_W'(cfg.ratio_x);
			pyr_s1 <= PR_W'(y_in) * PR_W'(cfg.ratio_y);
			sum_s1 <= SUM_W'(x_in) + SUM_W'(y_in) + SUM_W'(z_in);
			y_s1   <= y_in;
		end
		if (ctl.en[1]) begin
			num_s2 <= num;
			xp_s2  <= XP_W'(pxr_s1) * XP_W'(cfg.recip_ratio_y);
			y_s2   <= y_s1;
		end
		if (ctl.en[2]) begin
			zp_s3 <= ZP_W'(num_s2) * ZP_W'($signed({1'b0, cfg.recip_ratio_y}));
			xr_s3 <= XR_W'(((XP_W + 1)'(xp_s2) + X_HALF) >> SH);
			y_s3  <= y_s2;
		end
		if (ctl.en[3]) begin
			zr_s4 <= ZR_W'((zp_s3 + Z_HALF) >>> SH);
			xr_s4 <= xr_s3;
			y_s4  <= y_s3;
		end
		if (ctl.en[4]) begin
			zr_s5 <= zr_s4;
			xr_s5 <= xr_s4;
			y_s5  <= y_s4;
		end
		if (ctl.en[5]) begin
			zr_s6 <= zr_s5;
			xr_s6 <= xr_s5;
			y_s6  <= y_s5;
		end
	end

	assign res_x = xr_s6;
	assign res_y = y_s6;
	assign res_z = zr_s6;

endmodule
`default_nettype wire

### rtl/xyz_white_balance_pixel_top.sv
// Top level of the XYZ pixel white balance pipeline
//
//  channel | direction | handshake            | payload
//  s_*     | in        | s_tvalid / s_tready  | s_tdata: x_in, y_in, z_in
//  m_*     | out       | m_tvalid / m_tready  | m_tdata: x_out, y_out, z_out; m_tuser: saturated
//  cfg_*   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel per clock, while m_tready does not stall the output, through seven
// register stages; the depth is set by the two CAT02 matrix passes and the gain
// multiply of LMS mode. Reset clears the valid bits and loads unity ratios and
// gains, chromaticity mode. Each stage loads when empty or draining, so a stalled
// output holds every full stage behind it and bubbles are squeezed out. cfg_ready
// is always high.
`default_nettype none
module xyz_white_balance_pixel_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // x_in [15:0], y_in [31:16], z_in [47:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // x_out [17:0], y_out [35:18], z_out [53:36], zero pad
	output logic             m_tuser,   // saturated
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int PW    = wbp_pkg::PIX_W;
	localparam int OW    = wbp_pkg::OUT_W;
	localparam int SW    = wbp_pkg::SEL_W;
	localparam int LAST  = wbp_pkg::NUM_STAGES - 1;

	wbp_pkg::cfg_t      cfg;
	wbp_pkg::pipe_ctl_t ctl;

	logic [PW-1:0] x_in, y_in, z_in;

	logic signed [wbp_pkg::LMS_RES_W-1:0] lms_x, lms_y, lms_z;
	logic [wbp_pkg::CHR_X_W-1:0]          chr_x;
	logic [PW-1:0]                        chr_y;
	logic signed [wbp_pkg::CHR_Z_W-1:0]   chr_z;

	logic signed [SW-1:0] sel_x, sel_y, sel_z;
	logic [OW:0]          clip_x, clip_y, clip_z;

	logic [OW-1:0] x_out_s7, y_out_s7, z_out_s7;
	logic          sat_s7;

	// clip to signed output range; top bit flags a clip
	function automatic logic [OW:0] clip_res(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'(2**(OW-1) - 1);
		lo = -SW'(2**(OW-1));
		if (v > hi) begin
			clip_res = {1'b1, hi[OW-1:0]};
		end else if (v < lo) begin
			clip_res = {1'b1, lo[OW-1:0]};
		end else begin
			clip_res = {1'b0, v[OW-1:0]};
		end
	endfunction

	assign x_in = s_tdata[PW-1:0];
	assign y_in = s_tdata[2*PW-1:PW];
	assign z_in = s_tdata[3*PW-1:2*PW];

	wbp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wbp_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	wbp_lms_path u_lms (
		.clk   (clk),
		.ctl   (ctl),
		.cfg   (cfg),
		.x_in  (x_in),
		.y_in  (y_in),
		.z_in  (z_in),
		.res_x (lms_x),
		.res_y (lms_y),
		.res_z (lms_z)
	);

	wbp_chroma_path u_chroma (
		.clk   (clk),
		.ctl   (ctl),
		.cfg   (cfg),
		.x_in  (x_in),
		.y_in  (y_in),
		.z_in  (z_in),
		.res_x (chr_x),
		.res_y (chr_y),
		.res_z (chr_z)
	);

	// the user must keep the mode static while pixels are in flight; the block does not enforce it
	always_comb begin
		if (cfg.use_lms) begin
			sel_x = SW'(lms_x);
			sel_y = SW'(lms_y);
			sel_z = SW'(lms_z);
		end else begin
			sel_x = $signed(SW'(chr_x));
			sel_y = $signed(SW'(chr_y));
			sel_z = SW'(chr_z);
		end
		clip_x = clip_res(sel_x);
		clip_y = clip_res(sel_y);
		clip_z = clip_res(sel_z);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[LAST]) begin
			x_out_s7 <= clip_x[OW-1:0];
			y_out_s7 <= clip_y[OW-1:0];
			z_out_s7 <= clip_z[OW-1:0];
			sat_s7   <= clip_x[OW] | clip_y[OW] | clip_z[OW];
		end
	end

	assign m_tdata = {2'b00, z_out_s7, y_out_s7, x_out_s7};
	assign m_tuser = sat_s7;

endmodule
`default_nettype wire

### rtl/wbp_checker.sv
// Port-level checks of the white balance top level, bound to it
`default_nettype none
`include "assert_macros.svh"
module wbp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	localparam logic [17:0] OUT_HI = 18'h1FFFF;
	localparam logic [17:0] OUT_LO = 18'h20000;

	logic        out_stall;
	logic        out_free;
	logic [56:0] out_word;
	logic        at_limit;

	assign out_stall = m_tvalid && !m_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign out_word  = {m_tuser, m_tdata};
	assign at_limit  = m_tdata[17:0] == OUT_HI || m_tdata[17:0] == OUT_LO
		|| m_tdata[35:18] == OUT_HI || m_tdata[35:18] == OUT_LO
		|| m_tdata[53:36] == OUT_HI || m_tdata[53:36] == OUT_LO;

	// hold a stalled result
	`WBP_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(out_word), "held result changed")

	// input side never blocks while the output register is empty or draining
	`WBP_ASSERT(a_no_false_stall, out_free |-> s_tready, "input stalled with the output free")

	// a clipped pixel has at least one channel pinned at a range limit
	`WBP_ASSERT(a_sat_at_limit, m_tvalid && m_tuser |-> at_limit, "no channel at a limit")

	// no result during reset, and config port always takes a transfer
	`WBP_ASSERT_RST(a_reset_quiet, !arst_n |=> !m_tvalid, "result shown during reset")
	`WBP_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "config transfer refused")

endmodule

bind xyz_white_balance_pixel_top wbp_checker u_wbp_checker (.*);
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the XYZ pixel white balance pipeline
`default_nettype none
module tb;

	localparam logic [2:0] REG_BEYOND_LIST = 3'd7;
	localparam int         TAIL_CYCLES     = 16;
	localparam longint     RUN_LIMIT       = 64'd4_000_000;

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic               sat;
	} wb_pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // x_in [15:0], y_in [31:16], z_in [47:32]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // x_out [17:0], y_out [35:18], z_out [53:36], zero pad
	logic        m_tuser;   // saturated
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	wbp_pkg::cfg_t wb_cfg;
	wb_pixel_t     balanced_pixels_due [$];
	int unsigned   mismatch_count;
	int unsigned   burst_left;
	int unsigned   hold_requests;

	xyz_white_balance_pixel_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [17:0] clip18(longint v, inout logic sat);
		if (v > 131071) begin
			sat = 1'b1;
			return 18'sd131071;
		end
		if (v < -131072) begin
			sat = 1'b1;
			return -18'sd131072;
		end
		return v[17:0];
	endfunction

	function automatic wb_pixel_t balance_pixel(logic [15:0] xi, logic [15:0] yi,
			logic [15:0] zi);
		longint    px, py, pz, l, m, s, rx, rz, num;
		wb_pixel_t res;
		px = xi;
		py = yi;
		pz = zi;
		res.sat = 1'b0;
		if (wb_cfg.use_lms) begin
			// forward CAT02 in Q.16, keep eight extra fraction bits
			l = round_half_up(48025 * px + 28154 * py - 10643 * pz, 8);
			m = round_half_up(-46111 * px + 111247 * py + 400 * pz, 8);
			s = round_half_up(197 * px + 891 * py + 64448 * pz, 8);
			l = round_half_up(l * longint'(wb_cfg.gain_l), 12);
			m = round_half_up(m * longint'(wb_cfg.gain_m), 12);
			s = round_half_up(s * longint'(wb_cfg.gain_s), 12);
			rx = round_half_up(71834 * l - 18278 * m + 11973 * s, 24);
			py = round_half_up(29780 * l + 31031 * m + 4725 * s, 24);
			rz = round_half_up(-629 * l - 374 * m + 66539 * s, 24);
		end else begin
			num = (px + py + pz) * 4096 - longint'(wb_cfg.ratio_x) * px
				- longint'(wb_cfg.ratio_y) * py;
			rx = round_half_up(px * longint'(wb_cfg.ratio_x)
				* longint'(wb_cfg.recip_ratio_y), 24);
			rz = round_half_up(num * longint'(wb_cfg.recip_ratio_y), 24);
		end
		res.x = clip18(rx, res.sat);
		res.y = clip18(py, res.sat);
		res.z = clip18(rz, res.sat);
		return res;
	endfunction

	// Receiver: shifting stall pattern, plus long hold-offs on request
	initial begin : receiver
		int unsigned hold_served;
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned stall_mode;
		int unsigned phase_cnt;
		hold_served = 0;
		hold_left   = 0;
		mode_left   = 0;
		stall_mode  = 0;
		phase_cnt   = 0;
		m_tready    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = 300;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 4);
				mode_left  = $urandom_range(20, 200);
			end
			mode_left--;
			phase_cnt++;
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (stall_mode)
					0, 1: m_tready <= 1'b1;
					2: m_tready <= ($urandom_range(0, 3) != 0);
					3: m_tready <= ((phase_cnt % 5) >= 2);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Compare every output transfer with the oldest pending pixel
	always @(posedge clk) begin
		wb_pixel_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (balanced_pixels_due.size() == 0) begin
				$error("output transfer with no pixel pending");
				mismatch_count++;
			end else begin
				due = balanced_pixels_due.pop_front();
				if ($signed(m_tdata[17:0]) !== due.x) begin
					$error("x_out expected %0d got %0d", due.x, $signed(m_tdata[17:0]));
					mismatch_count++;
				end
				if ($signed(m_tdata[35:18]) !== due.y) begin
					$error("y_out expected %0d got %0d", due.y, $signed(m_tdata[35:18]));
					mismatch_count++;
				end
				if ($signed(m_tdata[53:36]) !== due.z) begin
					$error("z_out expected %0d got %0d", due.z, $signed(m_tdata[53:36]));
					mismatch_count++;
				end
				if (m_tuser !== due.sat) begin
					$error("saturated expected %0d got %0d", due.sat, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			wbp_pkg::REG_USE_LMS:  wb_cfg.use_lms       = val[0];
			wbp_pkg::REG_RATIO_X:  wb_cfg.ratio_x       = val;
			wbp_pkg::REG_RATIO_Y:  wb_cfg.ratio_y       = val;
			wbp_pkg::REG_RECIP_RY: wb_cfg.recip_ratio_y = val;
			wbp_pkg::REG_GAIN_L:   wb_cfg.gain_l        = val;
			wbp_pkg::REG_GAIN_M:   wb_cfg.gain_m        = val;
			wbp_pkg::REG_GAIN_S:   wb_cfg.gain_s        = val;
			default: ;
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic program_balance(wbp_pkg::cfg_t c);
		write_reg(wbp_pkg::REG_USE_LMS, {15'd0, c.use_lms}, 1'b0);
		write_reg(wbp_pkg::REG_RATIO_X, c.ratio_x, 1'b0);
		write_reg(wbp_pkg::REG_RATIO_Y, c.ratio_y, 1'b0);
		write_reg(wbp_pkg::REG_RECIP_RY, c.recip_ratio_y, 1'b0);
		write_reg(wbp_pkg::REG_GAIN_L, c.gain_l, 1'b0);
		write_reg(wbp_pkg::REG_GAIN_M, c.gain_m, 1'b0);
		write_reg(wbp_pkg::REG_GAIN_S, c.gain_s, 1'b1);
	endtask

	// Offer one pixel, inserting a random gap, which may be empty, whenever a burst runs out
	task automatic send_pixel(logic [15:0] xi, logic [15:0] yi, logic [15:0] zi);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {zi, yi, xi};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		balanced_pixels_due.push_back(balance_pixel(xi, yi, zi));
	endtask

	// Stop offering and let every pending pixel come out
	task automatic drain;
		s_tvalid <= 1'b0;
		while (balanced_pixels_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'd4096;
			3: return 16'($urandom_range(2048, 8192));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_pixel_value();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 20000));
			1: return 16'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 16'hFFFC : 16'h0);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults;
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000, 16'h0000);
		send_pixel(16'h4000, 16'h4000, 16'h4000);
		drain();
	endtask

	task automatic test_chroma_extremes;
		wbp_pkg::cfg_t c;
		c = '{use_lms: 1'b0, ratio_x: 16'hFFFF, ratio_y: 16'h0000, recip_ratio_y: 16'hFFFF,
			gain_l: 16'd4096, gain_m: 16'd4096, gain_s: 16'd4096};
		program_balance(c);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h0000, 16'hFFFF, 16'h0000);
		drain();
		// zero ratios and zero reciprocal
		c.ratio_x = 16'h0000;
		c.recip_ratio_y = 16'h0000;
		program_balance(c);
		send_pixel(16'hFFFF, 16'h1234, 16'hFFFF);
		drain();
		// large ratios drive Z negative, with a reciprocal that does not match ratio_y
		c = '{use_lms: 1'b0, ratio_x: 16'd8192, ratio_y: 16'hFFFF, recip_ratio_y: 16'd8192,
			gain_l: 16'd4096, gain_m: 16'd4096, gain_s: 16'd4096};
		program_balance(c);
		send_pixel(16'h0000, 16'hFFFF, 16'h0000);
		send_pixel(16'hFFFF, 16'h0000, 16'h0001);
		send_pixel(16'h8000, 16'h8000, 16'h0000);
		drain();
	endtask

	task automatic test_lms_extremes;
		wbp_pkg::cfg_t c;
		c = '{use_lms: 1'b1, ratio_x: 16'd4096, ratio_y: 16'd4096, recip_ratio_y: 16'd4096,
			gain_l: 16'hFFFF, gain_m: 16'h0000, gain_s: 16'hFFFF};
		program_balance(c);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000, 16'h0000);
		send_pixel(16'h0000, 16'h0000, 16'hFFFF);
		drain();
		c.gain_l = 16'h0000;
		c.gain_m = 16'hFFFF;
		c.gain_s = 16'h0000;
		program_balance(c);
		send_pixel(16'h0000, 16'hFFFF, 16'h0000);
		send_pixel(16'h0001, 16'h0001, 16'h0001);
		drain();
		c.gain_l = 16'd4096;
		c.gain_m = 16'd4096;
		c.gain_s = 16'd4096;
		program_balance(c);
		send_pixel(16'h3C00, 16'h4000, 16'h4500);
		drain();
	endtask

	task automatic test_config_masking;
		// only bit 0 of use_lms is kept; index past the list is ignored
		write_reg(wbp_pkg::REG_USE_LMS, 16'hFFFE, 1'b0);
		write_reg(REG_BEYOND_LIST, 16'h5A5A, 1'b1);
		send_pixel(16'h2000, 16'h6000, 16'hA000);
		drain();
		write_reg(wbp_pkg::REG_USE_LMS, 16'h0001, 1'b0);
		write_reg(REG_BEYOND_LIST, 16'hFFFF, 1'b1);
		send_pixel(16'h2000, 16'h6000, 16'hA000);
		drain();
	endtask

	task automatic test_output_hold;
		int unsigned n;
		hold_requests++;
		for (n = 0; n < 60; n++)
			send_pixel(pick_pixel_value(), pick_pixel_value(), pick_pixel_value());
		drain();
	endtask

	task automatic test_random_balance;
		wbp_pkg::cfg_t c;
		int unsigned   ph;
		int unsigned   n;
		for (ph = 0; ph < 12; ph++) begin
			c.use_lms       = ph[0];
			c.ratio_x       = pick_reg_value();
			c.ratio_y       = pick_reg_value();
			// mostly a matching reciprocal, sometimes anything at all
			if (c.ratio_y != 0 && $urandom_range(0, 2) != 0)
				c.recip_ratio_y = 16'((32'd16777216 + c.ratio_y / 2) / c.ratio_y);
			else
				c.recip_ratio_y = pick_reg_value();
			c.gain_l        = pick_reg_value();
			c.gain_m        = pick_reg_value();
			c.gain_s        = pick_reg_value();
			program_balance(c);
			for (n = 0; n < 150; n++)
				send_pixel(pick_pixel_value(), pick_pixel_value(), pick_pixel_value());
			drain();
		end
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("xyz_white_balance_pixel_top: mismatch");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		mismatch_count = 0;
		burst_left     = 0;
		hold_requests  = 0;
		wb_cfg = '{use_lms: 1'b0, ratio_x: 16'd4096, ratio_y: 16'd4096,
			recip_ratio_y: 16'd4096, gain_l: 16'd4096, gain_m: 16'd4096, gain_s: 16'd4096};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);

		test_reset_defaults();
		test_chroma_extremes();
		test_lms_extremes();
		test_config_masking();
		test_output_hold();
		test_random_balance();
		drain();

		if (mismatch_count == 0)
			$display("xyz_white_balance_pixel_top: match");
		else
			$display("xyz_white_balance_pixel_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/wbp_pkg.sv
rtl/wbp_cfg_regs.sv
rtl/wbp_pipe_ctrl.sv
rtl/wbp_lms_path.sv
rtl/wbp_chroma_path.sv
rtl/xyz_white_balance_pixel_top.sv
rtl/wbp_checker.sv
bench/tb.sv
